// ===== rtl/assert_macros.svh =====
// Assertion helpers; clk_i and rst_ni of the enclosing module are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MZ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define MZ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/mzts_pkg.sv =====
package mzts_pkg;

  localparam int unsigned KwMaxLen = 10;
  localparam int unsigned KwCount  = 47;
  localparam int unsigned MaxDepth = 255;

  // token kinds beyond the keyword range
  localparam logic [6:0] K_IDENT    = 7'd45;
  localparam logic [6:0] K_QIDENT   = 7'd46;
  localparam logic [6:0] K_ANON     = 7'd47;
  localparam logic [6:0] K_INT      = 7'd48;
  localparam logic [6:0] K_FLOAT    = 7'd49;
  localparam logic [6:0] K_STRING   = 7'd50;
  localparam logic [6:0] K_BOOL     = 7'd51;
  localparam logic [6:0] K_AND      = 7'd52;
  localparam logic [6:0] K_OR       = 7'd53;
  localparam logic [6:0] K_DIV      = 7'd54;
  localparam logic [6:0] K_IFF      = 7'd55;
  localparam logic [6:0] K_IMPLBY   = 7'd56;
  localparam logic [6:0] K_LE       = 7'd57;
  localparam logic [6:0] K_NEQ      = 7'd58;
  localparam logic [6:0] K_ROPEN    = 7'd59;
  localparam logic [6:0] K_RHALFR   = 7'd60;
  localparam logic [6:0] K_LT       = 7'd61;
  localparam logic [6:0] K_GE       = 7'd62;
  localparam logic [6:0] K_GT       = 7'd63;
  localparam logic [6:0] K_EQ       = 7'd64;
  localparam logic [6:0] K_IMPL     = 7'd65;
  localparam logic [6:0] K_MINUS    = 7'd66;
  localparam logic [6:0] K_CONCAT   = 7'd67;
  localparam logic [6:0] K_PLUS     = 7'd68;
  localparam logic [6:0] K_MUL      = 7'd69;
  localparam logic [6:0] K_POW      = 7'd70;
  localparam logic [6:0] K_RHALFL   = 7'd71;
  localparam logic [6:0] K_RANGE    = 7'd72;
  localparam logic [6:0] K_DOT      = 7'd73;
  localparam logic [6:0] K_ANNSTART = 7'd74;
  localparam logic [6:0] K_COLON    = 7'd75;
  localparam logic [6:0] K_SEMI     = 7'd76;
  localparam logic [6:0] K_COMMA    = 7'd77;
  localparam logic [6:0] K_LPAREN   = 7'd78;
  localparam logic [6:0] K_RPAREN   = 7'd79;
  localparam logic [6:0] K_LBRACK   = 7'd80;
  localparam logic [6:0] K_RBRACK   = 7'd81;
  localparam logic [6:0] K_LBRACE   = 7'd82;
  localparam logic [6:0] K_RBRACE   = 7'd83;
  localparam logic [6:0] K_PIPE     = 7'd84;
  localparam logic [6:0] K_AMP      = 7'd85;
  localparam logic [6:0] K_END      = 7'd86;
  localparam logic [6:0] K_ERROR    = 7'd87;

  // error codes
  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_BADCHAR = 3'd1;
  localparam logic [2:0] E_BSLASH  = 3'd2;
  localparam logic [2:0] E_BANG    = 3'd3;
  localparam logic [2:0] E_LTDOT   = 3'd4;
  localparam logic [2:0] E_OPENQ   = 3'd5;
  localparam logic [2:0] E_OPENSTR = 3'd6;

  typedef logic [KwMaxLen-1:0][7:0] wbuf_t;

  // keyword text, right justified: last char in the low byte
  localparam logic [8*KwMaxLen-1:0] KW_TEXT [KwCount] = '{
    "var", "par", "opt", "set", "of", "array", "list", "tuple", "record", "enum",
    "bool", "int", "float", "string", "ann", "any", "constraint", "solve",
    "satisfy", "minimize", "maximize", "output", "predicate", "function", "test",
    "include", "if", "then", "else", "elseif", "endif", "let", "in", "where",
    "annotation", "not", "div", "mod", "xor", "union", "intersect", "diff",
    "symdiff", "subset", "superset", "true", "false"
  };
  localparam logic [3:0] KW_LEN [KwCount] = '{
    4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd5, 4'd4, 4'd5, 4'd6, 4'd4,
    4'd4, 4'd3, 4'd5, 4'd6, 4'd3, 4'd3, 4'd10, 4'd5,
    4'd7, 4'd8, 4'd8, 4'd6, 4'd9, 4'd8, 4'd4,
    4'd7, 4'd2, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd2, 4'd5,
    4'd10, 4'd3, 4'd3, 4'd3, 4'd3, 4'd5, 4'd9, 4'd4,
    4'd7, 4'd6, 4'd8, 4'd4, 4'd5
  };

  // one result word
  typedef struct packed {
    logic [6:0]  kind;
    logic [2:0]  err;
    logic [31:0] start;
    logic [15:0] len;
    logic [23:0] line;
    logic [15:0] col;
  } res_t;

endpackage

// ===== rtl/mzts_kw_match.sv =====
module mzts_kw_match import mzts_pkg::*; (
  input  wbuf_t       wbuf_i,
  input  logic [15:0] len_i,
  output logic [6:0]  kind_o
);

  logic [KwCount-1:0] hit;

  always_comb begin
    for (int i = 0; i < KwCount; i++) begin
      hit[i] = (len_i == 16'(KW_LEN[i]));
      for (int j = 0; j < KwMaxLen; j++) begin
        if (j < int'(KW_LEN[i])) begin
          if (wbuf_i[j] != KW_TEXT[i][8*(int'(KW_LEN[i])-1-j) +: 8]) hit[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    kind_o = K_IDENT;
    for (int i = KwCount - 1; i >= 0; i--) begin
      if (hit[i]) kind_o = (i < 45) ? 7'(i) : K_BOOL;
    end
  end

endmodule

// ===== rtl/minizinc_token_scanner.sv =====
// MiniZinc token scanner. Takes one source byte per word (or an end-of-source
// marker) and returns 0 to 3 token words for it; the whole scan step for a byte
// is done in the cycle it is accepted and its tokens appear from the next cycle
// on, one per cycle while out_ready_i is high, in a 3-deep result buffer. A byte
// is taken every cycle while each byte yields at most one token and out_ready_i
// is high; a byte with more holds input off until one is left in the buffer.
// There is no clearing pass after reset. After an error token bytes are dropped
// until an end-of-source word, which produces nothing and restarts the scanner.
// At end of source the pending token is flushed, then END unless it is an error.
`include "assert_macros.svh"

module minizinc_token_scanner import mzts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  src_byte_i,
  input  logic        end_of_source_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  token_kind_o,
  output logic [2:0]  error_code_o,
  output logic [31:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic [23:0] line_number_o,
  output logic [15:0] column_number_o,
  output logic        last_of_run_o
);

  typedef enum logic [4:0] {
    M_IDLE, M_LINECMT, M_CMT, M_CMT_SLASH, M_CMT_STAR, M_WORD, M_UNDER,
    M_QUOTE, M_STR, M_STR_ESC, M_NUM_INT, M_NUM_DOT, M_NUM_FRAC,
    M_NUM_EXPS, M_NUM_EXPD, M_SLASH, M_BSLASH, M_LT, M_LT_DASH, M_LT_DOT,
    M_LT_DOTDOT, M_GT, M_EQ, M_BANG, M_MINUS, M_PLUS, M_DOT, M_DOTDOT,
    M_COLON
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    wbuf_t       wbuf;
    logic [31:0] tbeg;
    logic [31:0] pos;
    logic [15:0] len;
    logic [23:0] line;
    logic [15:0] col;
    logic [7:0]  depth;
    logic [7:0]  held;
    logic        stopped;
  } st_t;

  localparam st_t RESET_ST = '{mode: M_IDLE, wbuf: '0, tbeg: '0, pos: '0, len: '0,
                               line: 24'd1, col: 16'd1, depth: '0, held: '0,
                               stopped: 1'b0};

  // character codes
  localparam logic [7:0] CH_SP = 8'h20, CH_TAB = 8'h09, CH_CR = 8'h0D, CH_LF = 8'h0A;
  localparam logic [7:0] CH_PCT = 8'h25, CH_US = 8'h5F, CH_SQ = 8'h27, CH_DQ = 8'h22;
  localparam logic [7:0] CH_SL = 8'h2F, CH_BS = 8'h5C, CH_LTC = 8'h3C, CH_GTC = 8'h3E;
  localparam logic [7:0] CH_EQC = 8'h3D, CH_EXC = 8'h21, CH_MIN = 8'h2D, CH_PLS = 8'h2B;
  localparam logic [7:0] CH_DOTC = 8'h2E, CH_COL = 8'h3A, CH_STAR = 8'h2A, CH_CAR = 8'h5E;
  localparam logic [7:0] CH_SEM = 8'h3B, CH_COM = 8'h2C, CH_LP = 8'h28, CH_RP = 8'h29;
  localparam logic [7:0] CH_LB = 8'h5B, CH_RB = 8'h5D, CH_LC = 8'h7B, CH_RC = 8'h7D;
  localparam logic [7:0] CH_BAR = 8'h7C, CH_AMPC = 8'h26, CH_LE = 8'h65, CH_UE = 8'h45;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_wordc(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_US);
  endfunction

  function automatic st_t absorb(st_t si, logic [7:0] b);
    st_t s;
    s = si;
    if (s.len < 16'(KwMaxLen)) s.wbuf[s.len[3:0]] = b;
    if (s.len != 16'hFFFF) s.len = s.len + 16'd1;
    s.pos = s.pos + 32'd1;
    if (b == CH_LF) begin
      if (s.line != 24'hFFFFFF) s.line = s.line + 24'd1;
      s.col = 16'd1;
    end else if (s.col != 16'hFFFF) begin
      s.col = s.col + 16'd1;
    end
    return s;
  endfunction

  function automatic res_t mk(st_t s, logic [6:0] kind, logic [2:0] err);
    res_t r;
    r.kind  = kind;
    r.err   = err;
    r.start = s.tbeg;
    r.len   = s.len;
    r.line  = s.line;
    r.col   = s.col;
    return r;
  endfunction

  // One visit of the byte to the mode machine; used=0 means look at it again.
  function automatic void scan_pass(input st_t si, input logic [7:0] b,
                                    input logic [6:0] kw, output st_t so,
                                    output logic used, output logic rv,
                                    output res_t r);
    st_t s;
    logic [6:0] k;
    logic [2:0] e;
    logic em, fl;
    s = si;
    used = 1'b1;
    k = K_IDENT;
    e = E_NONE;
    em = 1'b0;
    fl = 1'b0;
    unique case (s.mode)
      M_IDLE: begin
        if (b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF) begin
          s = absorb(s, b);
        end else if (b == CH_PCT) begin
          s = absorb(s, b);
          s.mode = M_LINECMT;
        end else begin
          s.tbeg = s.pos;
          s.len = '0;
          s = absorb(s, b);
          em = 1'b1;
          case (b)
            CH_US:   begin em = 1'b0; s.mode = M_UNDER;  end
            CH_SQ:   begin em = 1'b0; s.mode = M_QUOTE;  end
            CH_DQ:   begin em = 1'b0; s.mode = M_STR;    end
            CH_SL:   begin em = 1'b0; s.mode = M_SLASH;  end
            CH_BS:   begin em = 1'b0; s.mode = M_BSLASH; end
            CH_LTC:  begin em = 1'b0; s.mode = M_LT;     end
            CH_GTC:  begin em = 1'b0; s.mode = M_GT;     end
            CH_EQC:  begin em = 1'b0; s.mode = M_EQ;     end
            CH_EXC:  begin em = 1'b0; s.mode = M_BANG;   end
            CH_MIN:  begin em = 1'b0; s.mode = M_MINUS;  end
            CH_PLS:  begin em = 1'b0; s.mode = M_PLUS;   end
            CH_DOTC: begin em = 1'b0; s.mode = M_DOT;    end
            CH_COL:  begin em = 1'b0; s.mode = M_COLON;  end
            CH_STAR: k = K_MUL;
            CH_CAR:  k = K_POW;
            CH_SEM:  k = K_SEMI;
            CH_COM:  k = K_COMMA;
            CH_LP:   k = K_LPAREN;
            CH_RP:   k = K_RPAREN;
            CH_LB:   k = K_LBRACK;
            CH_RB:   k = K_RBRACK;
            CH_LC:   k = K_LBRACE;
            CH_RC:   k = K_RBRACE;
            CH_BAR:  k = K_PIPE;
            CH_AMPC: k = K_AMP;
            default: begin
              em = 1'b0;
              if (is_alpha(b)) s.mode = M_WORD;
              else if (is_digit(b)) s.mode = M_NUM_INT;
              else begin fl = 1'b1; e = E_BADCHAR; end
            end
          endcase
        end
      end
      M_LINECMT: begin
        s = absorb(s, b);
        if (b == CH_LF) s.mode = M_IDLE;
      end
      M_CMT: begin
        s = absorb(s, b);
        if (b == CH_SL) s.mode = M_CMT_SLASH;
        else if (b == CH_STAR) s.mode = M_CMT_STAR;
      end
      M_CMT_SLASH: begin
        s.mode = M_CMT;
        if (b != CH_STAR) used = 1'b0;
        else begin
          s = absorb(s, b);
          if (s.depth != 8'(MaxDepth)) s.depth = s.depth + 8'd1;
        end
      end
      M_CMT_STAR: begin
        s.mode = M_CMT;
        if (b != CH_SL) used = 1'b0;
        else begin
          s = absorb(s, b);
          if (s.depth != 8'd0) s.depth = s.depth - 8'd1;
          if (s.depth == 8'd0) s.mode = M_IDLE;
        end
      end
      M_UNDER: begin
        if (!is_wordc(b)) begin em = 1'b1; k = K_ANON; used = 1'b0; end
        else begin s = absorb(s, b); s.mode = M_WORD; end
      end
      M_WORD: begin
        if (!is_wordc(b)) begin em = 1'b1; k = kw; used = 1'b0; end
        else s = absorb(s, b);
      end
      M_QUOTE: begin
        s = absorb(s, b);
        if (b == CH_SQ) begin em = 1'b1; k = K_QIDENT; end
      end
      M_STR: begin
        s = absorb(s, b);
        if (b == CH_BS) s.mode = M_STR_ESC;
        else if (b == CH_DQ) begin em = 1'b1; k = K_STRING; end
      end
      M_STR_ESC: begin
        s = absorb(s, b);
        s.mode = M_STR;
      end
      M_NUM_INT: begin
        if (is_digit(b)) s = absorb(s, b);
        else if (b == CH_DOTC) begin s.held = b; s.mode = M_NUM_DOT; end
        else if (b == CH_LE || b == CH_UE) begin s = absorb(s, b); s.mode = M_NUM_EXPS; end
        else begin em = 1'b1; k = K_INT; used = 1'b0; end
      end
      M_NUM_DOT: begin
        if (is_digit(b)) begin
          s = absorb(s, s.held);
          s = absorb(s, b);
          s.mode = M_NUM_FRAC;
        end else begin
          // integer ends here; the held dot opens a new token
          r = mk(s, K_INT, E_NONE);
          s.tbeg = s.pos;
          s.len = '0;
          s = absorb(s, s.held);
          s.mode = M_DOT;
          used = 1'b0;
        end
      end
      M_NUM_FRAC: begin
        if (is_digit(b)) s = absorb(s, b);
        else if (b == CH_LE || b == CH_UE) begin s = absorb(s, b); s.mode = M_NUM_EXPS; end
        else begin em = 1'b1; k = K_FLOAT; used = 1'b0; end
      end
      M_NUM_EXPS: begin
        if (b == CH_PLS || b == CH_MIN || is_digit(b)) begin
          s = absorb(s, b);
          s.mode = M_NUM_EXPD;
        end else begin em = 1'b1; k = K_FLOAT; used = 1'b0; end
      end
      M_NUM_EXPD: begin
        if (is_digit(b)) s = absorb(s, b);
        else begin em = 1'b1; k = K_FLOAT; used = 1'b0; end
      end
      M_SLASH: begin
        if (b == CH_BS) begin s = absorb(s, b); em = 1'b1; k = K_AND; end
        else if (b == CH_STAR) begin s = absorb(s, b); s.depth = 8'd1; s.mode = M_CMT; end
        else begin em = 1'b1; k = K_DIV; used = 1'b0; end
      end
      M_BSLASH: begin
        if (b == CH_SL) begin s = absorb(s, b); em = 1'b1; k = K_OR; end
        else begin fl = 1'b1; e = E_BSLASH; end
      end
      M_LT: begin
        if (b == CH_MIN) begin s = absorb(s, b); s.mode = M_LT_DASH; end
        else if (b == CH_EQC) begin s = absorb(s, b); em = 1'b1; k = K_LE; end
        else if (b == CH_GTC) begin s = absorb(s, b); em = 1'b1; k = K_NEQ; end
        else if (b == CH_DOTC) begin s = absorb(s, b); s.mode = M_LT_DOT; end
        else begin em = 1'b1; k = K_LT; used = 1'b0; end
      end
      M_LT_DASH: begin
        if (b == CH_GTC) begin s = absorb(s, b); em = 1'b1; k = K_IFF; end
        else begin em = 1'b1; k = K_IMPLBY; used = 1'b0; end
      end
      M_LT_DOT: begin
        if (b == CH_DOTC) begin s = absorb(s, b); s.mode = M_LT_DOTDOT; end
        else begin fl = 1'b1; e = E_LTDOT; end
      end
      M_LT_DOTDOT: begin
        if (b == CH_LTC) begin s = absorb(s, b); em = 1'b1; k = K_ROPEN; end
        else begin em = 1'b1; k = K_RHALFR; used = 1'b0; end
      end
      M_GT: begin
        if (b == CH_EQC) begin s = absorb(s, b); em = 1'b1; k = K_GE; end
        else begin em = 1'b1; k = K_GT; used = 1'b0; end
      end
      M_EQ: begin
        em = 1'b1;
        k = K_EQ;
        if (b == CH_EQC) s = absorb(s, b);
        else used = 1'b0;
      end
      M_BANG: begin
        if (b == CH_EQC) begin s = absorb(s, b); em = 1'b1; k = K_NEQ; end
        else begin fl = 1'b1; e = E_BANG; end
      end
      M_MINUS: begin
        if (is_digit(b)) begin s = absorb(s, b); s.mode = M_NUM_INT; end
        else if (b == CH_GTC) begin s = absorb(s, b); em = 1'b1; k = K_IMPL; end
        else begin em = 1'b1; k = K_MINUS; used = 1'b0; end
      end
      M_PLUS: begin
        if (b == CH_PLS) begin s = absorb(s, b); em = 1'b1; k = K_CONCAT; end
        else begin em = 1'b1; k = K_PLUS; used = 1'b0; end
      end
      M_DOT: begin
        if (b == CH_DOTC) begin s = absorb(s, b); s.mode = M_DOTDOT; end
        else begin em = 1'b1; k = K_DOT; used = 1'b0; end
      end
      M_DOTDOT: begin
        if (b == CH_LTC) begin s = absorb(s, b); em = 1'b1; k = K_RHALFL; end
        else begin em = 1'b1; k = K_RANGE; used = 1'b0; end
      end
      M_COLON: begin
        if (b == CH_COL) begin s = absorb(s, b); em = 1'b1; k = K_ANNSTART; end
        else begin em = 1'b1; k = K_COLON; used = 1'b0; end
      end
      default: begin
        s.mode = M_IDLE;
        used = 1'b0;
      end
    endcase
    rv = em || fl || (si.mode == M_NUM_DOT && !is_digit(b));
    if (em) begin
      r = mk(s, k, E_NONE);
      s.mode = M_IDLE;
    end else if (fl) begin
      r = mk(s, K_ERROR, e);
      s.mode = M_IDLE;
      s.stopped = 1'b1;
    end else if (!rv) begin
      r = '0;
    end
    so = s;
  endfunction

  st_t        state_q, state_d;
  logic [6:0] kw_kind;
  res_t       buf_q [3];
  res_t       buf_d [3];
  logic [1:0] cnt_q, cnt_d;

  mzts_kw_match u_kw (
    .wbuf_i (state_q.wbuf),
    .len_i  (state_q.len),
    .kind_o (kw_kind)
  );

  // scan step for the word at the input
  st_t        s1, s2, s3;
  logic       u1, u2, u3, v1, v2, v3;
  res_t       r1, r2, r3;
  res_t       pk [3];
  logic [1:0] n_res;

  always_comb begin
    st_t  s;
    logic [6:0] k;
    logic [2:0] e;
    logic       any;
    s = state_q;
    s1 = state_q; s2 = state_q; s3 = state_q;
    u1 = 1'b1; u2 = 1'b1; u3 = 1'b1;
    v1 = 1'b0; v2 = 1'b0; v3 = 1'b0;
    r1 = '0; r2 = '0; r3 = '0;
    k = K_END;
    e = E_NONE;
    any = 1'b0;
    if (state_q.stopped) begin
      state_d = end_of_source_i ? RESET_ST : state_q;
    end else if (end_of_source_i) begin
      any = 1'b1;
      case (s.mode)
        M_UNDER:                          k = K_ANON;
        M_WORD:                           k = kw_kind;
        M_QUOTE:                          begin k = K_ERROR; e = E_OPENQ; end
        M_STR, M_STR_ESC:                 begin k = K_ERROR; e = E_OPENSTR; end
        M_NUM_INT, M_NUM_DOT:             k = K_INT;
        M_NUM_FRAC, M_NUM_EXPS, M_NUM_EXPD: k = K_FLOAT;
        M_SLASH:                          k = K_DIV;
        M_BSLASH:                         begin k = K_ERROR; e = E_BSLASH; end
        M_LT:                             k = K_LT;
        M_LT_DASH:                        k = K_IMPLBY;
        M_LT_DOT:                         begin k = K_ERROR; e = E_LTDOT; end
        M_LT_DOTDOT:                      k = K_RHALFR;
        M_GT:                             k = K_GT;
        M_EQ:                             k = K_EQ;
        M_BANG:                           begin k = K_ERROR; e = E_BANG; end
        M_MINUS:                          k = K_MINUS;
        M_PLUS:                           k = K_PLUS;
        M_DOT:                            k = K_DOT;
        M_DOTDOT:                         k = K_RANGE;
        M_COLON:                          k = K_COLON;
        default:                          any = 1'b0;
      endcase
      if (any) begin
        v1 = 1'b1;
        r1 = mk(s, k, e);
      end
      if (s.mode == M_NUM_DOT) begin
        // trailing dot after integer digits becomes its own token
        s.tbeg = s.pos;
        s.len = '0;
        s = absorb(s, s.held);
        v2 = 1'b1;
        r2 = mk(s, K_DOT, E_NONE);
      end
      if (k != K_ERROR) begin
        v3 = 1'b1;
        r3 = '{kind: K_END, err: E_NONE, start: s.pos, len: '0,
               line: s.line, col: s.col};
      end
      state_d = RESET_ST;
    end else begin
      scan_pass(state_q, src_byte_i, kw_kind, s1, u1, v1, r1);
      s2 = s1;
      if (!u1 && !s1.stopped) scan_pass(s1, src_byte_i, kw_kind, s2, u2, v2, r2);
      s3 = s2;
      if (!u1 && !u2 && !s2.stopped) scan_pass(s2, src_byte_i, kw_kind, s3, u3, v3, r3);
      state_d = s3;
    end
  end

  // pack results to the front
  always_comb begin
    pk[0] = v1 ? r1 : (v2 ? r2 : r3);
    pk[1] = (v1 && v2) ? r2 : r3;
    pk[2] = r3;
    n_res = 2'(v1) + 2'(v2) + 2'(v3);
  end

  logic in_acc, out_acc;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (out_acc) begin
      buf_d[0] = buf_q[1];
      buf_d[1] = buf_q[2];
      cnt_d = cnt_q - 2'd1;
    end
    if (in_acc) begin
      buf_d = pk;
      cnt_d = n_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RESET_ST;
      cnt_q   <= '0;
      buf_q   <= '{default: '0};
    end else begin
      if (in_acc) state_q <= state_d;
      cnt_q <= cnt_d;
      buf_q <= buf_d;
    end
  end

  assign token_kind_o    = buf_q[0].kind;
  assign error_code_o    = buf_q[0].err;
  assign token_start_o   = buf_q[0].start;
  assign token_length_o  = buf_q[0].len;
  assign line_number_o   = buf_q[0].line;
  assign column_number_o = buf_q[0].col;
  assign last_of_run_o   = (cnt_q == 2'd1);

  `MZ_ASSERT_IMPL(a_err_kind, out_valid_o && token_kind_o == K_ERROR, error_code_o != E_NONE, "error token without code")
  `MZ_ASSERT_IMPL(a_ok_kind, out_valid_o && token_kind_o != K_ERROR, error_code_o == E_NONE, "code on non-error token")
  `MZ_ASSERT_IMPL(a_line_pos, out_valid_o, line_number_o != 24'd0 && column_number_o != 16'd0, "zero line or column")
  `MZ_ASSERT(a_stop_quiet, !(in_acc && state_q.stopped && n_res != 2'd0), "output while stopped")

endmodule
